// ===== src/bali_pkg.sv =====
// ----------------------------------------------------------------------------
// bali_pkg
// Shared codes and field widths for the bounded array list with positional
// insert, remove and read.
// ----------------------------------------------------------------------------
package bali_pkg;

  localparam int MODE_BITS   = 2;
  localparam int POS_BITS    = 4;
  localparam int DATA_BITS   = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;
  localparam int CAP_BITS    = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage

// ===== src/bali_if.sv =====
// ----------------------------------------------------------------------------
// bali_if
// Valid/ready channels of the array list: request beats in, response beats out.
// ----------------------------------------------------------------------------
interface bali_req_if;
  logic                           valid;
  logic                           ready;
  logic [bali_pkg::MODE_BITS-1:0] mode;
  logic [bali_pkg::POS_BITS-1:0]  position;
  logic [bali_pkg::DATA_BITS-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface bali_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bali_pkg::STATUS_BITS-1:0] status;
  logic [bali_pkg::DATA_BITS-1:0]   read_value;
  logic [bali_pkg::COUNT_BITS-1:0]  count;
  logic                             empty_flag;
  logic                             full_flag;

  modport source (output valid, output status, output read_value, output count,
                  output empty_flag, output full_flag, input ready);
  modport sink (input valid, input status, input read_value, input count,
                input empty_flag, input full_flag, output ready);
endinterface

// ===== src/bounded_array_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_insert_remove
// Ordered list of up to DEPTH values held in one synchronous memory; insert
// and remove move the later entries one place, one entry per cycle.
// Flow: a rejected beat goes straight to the response state; a read passes
//   through S_READ first; insert and remove first shift entries in S_INS or
//   S_REM; the response then waits on rsp ready.
// Throughput: one beat at a time; the memory's single read and write port
//   moves one entry per cycle, so shifts set the rate.
// Reset: list empty, capacity 16; memory contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_list_insert_remove #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  bali_req_if.sink                      req,
  bali_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [bali_pkg::CAP_BITS-1:0] cfg_wdata
);
  import bali_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_READ,
    S_DONE
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [CAP_BITS-1:0]   capacity;
  logic [MODE_BITS-1:0]  op_mode;
  status_t               op_status;
  logic [CMPW-1:0]       op_pos;
  logic [VALUE_BITS-1:0] op_val;
  logic [CW-1:0]         cur;
  logic                  pend;
  logic [AW-1:0]         pend_addr;

  logic                  out_valid;
  status_t               out_status;
  logic [DATA_BITS-1:0]  out_rdval;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_empty;
  logic                  out_full;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [CMPW-1:0]       eff_cap;
  logic [CMPW-1:0]       count_ext;
  logic [CMPW-1:0]       pos_in;
  logic [CMPW-1:0]       cur_ext;
  logic                  more_ins;
  logic                  more_rem;
  status_t               acc_status;
  logic [CW-1:0]         new_count;
  logic                  accept;
  logic                  out_load;

  assign count_ext = CMPW'(count);
  assign pos_in    = CMPW'(req.position);
  assign cur_ext   = CMPW'(cur);
  assign more_ins  = cur_ext > op_pos;
  assign more_rem  = (cur_ext + CMPW'(1)) < count_ext;
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(capacity) > CMPW'(DEPTH)) begin
      eff_cap = CMPW'(DEPTH);
    end else begin
      eff_cap = CMPW'(capacity);
    end
  end

  // request check against the committed count
  always_comb begin
    acc_status = ST_OK;
    unique case (req.mode)
      MODE_INSERT: begin
        if (count_ext >= eff_cap) begin
          acc_status = ST_FULL;
        end else if (pos_in > count_ext) begin
          acc_status = ST_BADPOS;
        end
      end
      MODE_REMOVE, MODE_READ: begin
        if (count == '0) begin
          acc_status = ST_EMPTY;
        end else if (pos_in >= count_ext) begin
          acc_status = ST_BADPOS;
        end
      end
      default: acc_status = ST_BADPOS;
    endcase
  end

  always_comb begin
    new_count = count;
    if (op_status == ST_OK && op_mode == MODE_INSERT) begin
      new_count = CW'(count + 1'b1);
    end else if (op_status == ST_OK && op_mode == MODE_REMOVE) begin
      new_count = CW'(count - 1'b1);
    end
  end

  // memory port control: read one entry ahead, write it back one place over
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    unique case (state)
      S_INS: begin
        wr_en = pend;
        if (more_ins) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cur - 1'b1);
        end else if (!pend) begin
          wr_en   = 1'b1;
          wr_addr = AW'(op_pos);
          wr_data = op_val;
        end
      end
      S_REM: begin
        wr_en = pend;
        if (more_rem) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cur + 1'b1);
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = AW'(op_pos);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cur       <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode   <= req.mode;
            op_status <= acc_status;
            op_pos    <= pos_in;
            op_val    <= VALUE_BITS'(req.value);
            pend      <= 1'b0;
            if (acc_status != ST_OK) begin
              state <= S_DONE;
            end else if (req.mode == MODE_INSERT) begin
              cur   <= count;
              state <= S_INS;
            end else if (req.mode == MODE_REMOVE) begin
              cur   <= CW'(req.position);
              state <= S_REM;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_INS: begin
          if (more_ins) begin
            pend      <= 1'b1;
            pend_addr <= AW'(cur);
            cur       <= CW'(cur - 1'b1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end
        S_REM: begin
          if (more_rem) begin
            pend      <= 1'b1;
            pend_addr <= AW'(cur);
            cur       <= CW'(cur + 1'b1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            count      <= new_count;
            out_valid  <= 1'b1;
            out_status <= op_status;
            out_rdval  <= (op_mode == MODE_READ && op_status == ST_OK) ?
                          DATA_BITS'(rd_data) : '0;
            out_count  <= COUNT_BITS'(new_count);
            out_empty  <= (new_count == '0);
            out_full   <= (CMPW'(new_count) >= eff_cap);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_rdval;
  assign rsp.count      = out_count;
  assign rsp.empty_flag = out_empty;
  assign rsp.full_flag  = out_full;

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en && !pend)
    else $error("memory write while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted beat did not start work");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("response not loaded");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_INS || state == S_REM)
    else $error("pending write outside a shift");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    out_load && op_status == ST_OK && op_mode == MODE_INSERT
    |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not bump the count");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the bounded array list against a cycle-free list model kept in the
// bench. A table of directed requests covers the empty, full and bad-position
// answers and capacity edge values. Phases of random inserts, removes and
// reads follow, each under its own capacity. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bali_pkg::*;

  localparam int DEPTH          = 16;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 65;
  localparam int NUM_PHASES     = 10;
  localparam int MAX_SHOWN      = 10;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    status_t                 status;
    logic [DATA_BITS-1:0]    read_value;
    logic [COUNT_BITS-1:0]   count;
    logic                    empty_flag;
    logic                    full_flag;
  } list_rsp_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CAP_BITS-1:0]   cap;
    logic [MODE_BITS-1:0]  mode;
    logic [POS_BITS-1:0]   position;
    logic [DATA_BITS-1:0]  value;
    logic                  typed;
    list_rsp_t             rsp;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [29] = '{
    '{1'b0, 5'd0,  MODE_READ,   4'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd15, 32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd1,  32'h0000_0001, 1'b1, '{ST_BADPOS, 32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_UNUSED, 4'd0,  32'h0000_0000, 1'b1, '{ST_BADPOS, 32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'hFFFF_FFFF, 1'b1, '{ST_OK,     32'h0, 5'd1, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_READ,   4'd0,  32'h0000_0000, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd1,  32'h0000_0000, 1'b1, '{ST_OK,     32'h0, 5'd2, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'h1234_5678, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_READ,   4'd1,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_READ,   4'd15, 32'h0000_0000, 1'b1, '{ST_BADPOS, 32'h0, 5'd3, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd3,  32'h0000_0000, 1'b1, '{ST_BADPOS, 32'h0, 5'd3, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd3,  32'hA5A5_A5A5, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd5,  32'h5A5A_5A5A, 1'b1, '{ST_BADPOS, 32'h0, 5'd4, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_READ,   4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b1, 5'd1,  MODE_INSERT, 4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'hDEAD_BEEF, 1'b1, '{ST_FULL,   32'h0, 5'd3, 1'b0, 1'b1}},
    '{1'b0, 5'd0,  MODE_READ,   4'd2,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd2,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_OK,     32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_REMOVE, 4'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0, 5'd0, 1'b1, 1'b0}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'h8000_0001, 1'b1, '{ST_OK,     32'h0, 5'd1, 1'b0, 1'b1}},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd5,  32'h0000_0007, 1'b1, '{ST_FULL,   32'h0, 5'd1, 1'b0, 1'b1}},
    '{1'b1, 5'd0,  MODE_INSERT, 4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'h0000_0003, 1'b1, '{ST_FULL,   32'h0, 5'd1, 1'b0, 1'b1}},
    '{1'b1, 5'd31, MODE_INSERT, 4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_INSERT, 4'd0,  32'h7FFF_FFFE, 1'b0, '0},
    '{1'b0, 5'd0,  MODE_READ,   4'd1,  32'h0000_0000, 1'b1,
      '{ST_OK, 32'h8000_0001, 5'd2, 1'b0, 1'b0}}
  };

  localparam logic [CAP_BITS-1:0] PHASE_CAPS [NUM_PHASES] = '{
    5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16, 5'd12
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  bali_req_if req_if();
  bali_rsp_if rsp_if();

  bounded_array_list_insert_remove uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [DATA_BITS-1:0] list_cells [DEPTH];
  int                   list_len;
  logic [CAP_BITS-1:0]  capacity_q;
  list_rsp_t            pending_rsp [$];
  int                   fault_count = 0;
  int                   idle_cycles = 0;
  bit                   tx_burst = 1'b0;
  bit                   rx_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to the list copy and returns the response it gives
  function automatic list_rsp_t list_apply(logic [MODE_BITS-1:0] m,
                                           logic [POS_BITS-1:0] pos,
                                           logic [DATA_BITS-1:0] val);
    list_rsp_t r;
    int        eff_cap;
    int        p;
    int        i;
    eff_cap = (capacity_q == 0) ? 1 : ((capacity_q > DEPTH) ? DEPTH : int'(capacity_q));
    p = int'(pos);
    r = '0;
    r.status = ST_OK;
    case (m)
      MODE_INSERT: begin
        if (list_len >= eff_cap) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = val;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      MODE_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = list_cells[p];
        end
      end
      default: begin
        r.status = ST_BADPOS;
      end
    endcase
    r.count      = list_len[COUNT_BITS-1:0];
    r.empty_flag = (list_len == 0);
    r.full_flag  = (list_len >= eff_cap);
    return r;
  endfunction

  task automatic send_beat(logic [MODE_BITS-1:0] m, logic [POS_BITS-1:0] pos,
                           logic [DATA_BITS-1:0] val, bit typed, list_rsp_t typed_rsp);
    int        gap;
    list_rsp_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = list_apply(m, pos, val);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // sender holds off until every outstanding response beat is back
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we     <= 1'b0;
    capacity_q = c;
  endtask

  task automatic collect_responses();
    int        stall;
    list_rsp_t got;
    list_rsp_t want;
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      got = '{status_t'(rsp_if.status), rsp_if.read_value, rsp_if.count,
              rsp_if.empty_flag, rsp_if.full_flag};
      if (pending_rsp.size() == 0) begin
        if (fault_count < MAX_SHOWN)
          $display("unexpected response beat at %0t: status %0d read_value %h count %0d",
                   $realtime, got.status, got.read_value, got.count);
        fault_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.count !== want.count || got.empty_flag !== want.empty_flag ||
            got.full_flag !== want.full_flag) begin
          if (fault_count < MAX_SHOWN) begin
            $display("response mismatch at %0t", $realtime);
            $display("  status     exp %0d got %0d", want.status, got.status);
            $display("  read_value exp %h got %h", want.read_value, got.read_value);
            $display("  count      exp %0d got %0d", want.count, got.count);
            $display("  empty/full exp %b%b got %b%b", want.empty_flag, want.full_flag,
                     got.empty_flag, got.full_flag);
          end
          fault_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int                   ph;
    int                   k;
    int                   roll;
    bit                   filling;
    logic [MODE_BITS-1:0] m;
    logic [POS_BITS-1:0]  pos;
    logic [DATA_BITS-1:0] val;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= MODE_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    rsp_if.ready    <= 1'b0;
    list_len   = 0;
    capacity_q = CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_responses();
    join_none

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].is_cfg)
        write_capacity(DIRECTED_ROWS[i].cap);
      else
        send_beat(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].position, DIRECTED_ROWS[i].value,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(PHASE_CAPS[ph]);
      tx_burst = (ph % 3 == 1);
      rx_burst = (ph % 4 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // alternate fill and drain stretches so full and empty both get hit
        filling = ((k / 16) % 2 == 0);
        roll = $urandom_range(0, 99);
        val = $urandom();
        if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 1) ? '1 : '0;
        if (roll < 6) begin
          m   = MODE_BITS'($urandom_range(0, 3));
          pos = POS_BITS'($urandom_range(0, 15));
        end else if (roll < 22) begin
          m   = MODE_READ;
          pos = POS_BITS'((list_len > 0) ? $urandom_range(0, list_len - 1) :
                                           $urandom_range(0, 15));
        end else if (roll < (filling ? 80 : 36)) begin
          m   = MODE_INSERT;
          pos = POS_BITS'($urandom_range(0, (list_len > 15) ? 15 : list_len));
        end else begin
          m   = MODE_REMOVE;
          pos = POS_BITS'((list_len > 0) ? $urandom_range(0, list_len - 1) :
                                           $urandom_range(0, 15));
        end
        if (ph == 5 && k == 30) quiesce();
        send_beat(m, pos, val, 1'b0, '0);
      end
    end

    quiesce();
    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
